// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros shared by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/lcg48_pkg.sv =====
// Shared types, constants and command codes of the 48-bit LCG draw engine.
`default_nettype none
package lcg48_pkg;

	// generator constants
	localparam int unsigned STATE_W = 48;
	localparam logic [34:0] LCG_MULT = 35'h5DEECE66D;
	localparam logic [STATE_W-1:0] LCG_INC = 48'hB;

	// parameter defaults
	localparam int unsigned MAX_BYTES_DEF = 64;
	localparam int unsigned CMD_DEPTH_DEF = 2;

	// remainder unit: one quotient bit per cycle
	localparam int unsigned DIV_W = 31;
	localparam int unsigned DIV_STEPS = DIV_W;

	// request codes as seen on the input tuser
	localparam logic [2:0] OP_BITS   = 3'd0;
	localparam logic [2:0] OP_BOUND  = 3'd1;
	localparam logic [2:0] OP_LONG   = 3'd2;
	localparam logic [2:0] OP_BOOL   = 3'd3;
	localparam logic [2:0] OP_FLOAT  = 3'd4;
	localparam logic [2:0] OP_DOUBLE = 3'd5;
	localparam logic [2:0] OP_BYTES  = 3'd6;

	// classified command held in the queue
	typedef struct packed {
		logic [2:0]       op;
		logic [5:0]       bits;
		logic [DIV_W-1:0] bound;
		logic             pow2;
		logic [6:0]       bytes;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lcg_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/lcg48_random_draw_engine.sv =====
// A request passes the front holding stage and the command queue; the sequencer then steps the
// generator once per draw: twice for long and double, once per byte for byte runs, and once per
// attempt for non-power-of-two bounds, each attempt followed by the remainder unit. The sequencer
// works on one command at a time; later requests wait in the queue while it is busy.
// Output stalls back up through the two-entry queue and front holding stage to s_tready.
// Reset loads the generator with 0x5DEECE66D and empties queue and output.
`default_nettype none
module lcg48_random_draw_engine #(
	parameter int unsigned MAX_BYTES = lcg48_pkg::MAX_BYTES_DEF,
	parameter int unsigned CMD_DEPTH = lcg48_pkg::CMD_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// seed register write
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lcg48_pkg::STATE_W-1:0] cfg_data,
	// request stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [47:0]                   s_tdata,  // bit_count[5:0], bound[36:6], byte_count[43:37]
	input  wire logic [2:0]                    s_tuser,  // op[2:0]
	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic signed [63:0]                 m_tdata,  // value[63:0]
	output logic                               m_tlast
);
	import lcg48_pkg::*;

	logic               q_push;
	cmd_t               q_wr_cmd;
	logic               q_full;
	logic               q_pop;
	logic               q_valid;
	cmd_t               q_rd_cmd;
	logic               lcg_start;
	lcg_rsp_t           lcg_rsp;
	logic [STATE_W-1:0] lcg_state;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign cfg_ready = 1'b1;

	lcg48_front #(.MAX_BYTES(MAX_BYTES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_push   (q_push),
		.q_cmd    (q_wr_cmd),
		.q_full   (q_full)
	);

	lcg48_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_cmd   (q_wr_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_rd_cmd)
	);

	lcg48_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (lcg_start),
		.seed_wr (cfg_valid),
		.seed    (cfg_data),
		.rsp     (lcg_rsp),
		.state   (lcg_state)
	);

	lcg48_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lcg48_back #(.MAX_BYTES(MAX_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_rd_cmd),
		.q_pop     (q_pop),
		.lcg_start (lcg_start),
		.lcg_rsp   (lcg_rsp),
		.lcg_state (lcg_state),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// checks
	`include "assert_macros.svh"

	`ASSERT_NEVER(a_step_div_overlap, lcg_rsp.busy && div_rsp.busy, "step and remainder unit both busy")
	`ASSERT_CLK(a_pop_starts_step, q_pop |=> lcg_rsp.busy, "command taken without a generator step")
	`ASSERT_CLK(a_result_after_step, $rose(m_tvalid) |-> !$past(lcg_rsp.busy), "result loaded mid-step")

endmodule
`default_nettype wire

// ===== rtl/core/lcg48_front.sv =====
// Front end: accepts requests, normalises and classifies them into commands.
`default_nettype none
module lcg48_front #(
	parameter int unsigned MAX_BYTES = lcg48_pkg::MAX_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [47:0]      s_tdata,
	input  wire logic [2:0]       s_tuser,
	output logic                  q_push,
	output lcg48_pkg::cmd_t       q_cmd,
	input  wire logic             q_full
);
	import lcg48_pkg::*;

	logic       in_acc;
	logic       keep;
	cmd_t       cmd;
	logic [5:0] bc;
	logic [30:0] bnd;
	logic [6:0] byc;
	logic       cmd_valid_s1;
	cmd_t       cmd_s1;

	assign bc  = s_tdata[5:0];
	assign bnd = s_tdata[36:6];
	assign byc = s_tdata[43:37];

	// classify: fold boolean and float into top-bit draws, drop empty byte runs and unknown op codes
	always_comb begin
		keep      = 1'b1;
		cmd.op    = s_tuser;
		cmd.bits  = bc;
		cmd.bound = bnd;
		cmd.pow2  = ((bnd & (bnd - 31'd1)) == '0);
		cmd.bytes = byc;
		case (s_tuser)
			OP_BITS: begin
				cmd.bits = (bc > 6'd32) ? 6'd32 : bc;
			end
			OP_BOOL: begin
				cmd.op   = OP_BITS;
				cmd.bits = 6'd1;
			end
			OP_FLOAT: begin
				cmd.op   = OP_BITS;
				cmd.bits = 6'd24;
			end
			OP_BOUND, OP_LONG, OP_DOUBLE: begin
				keep = 1'b1;
			end
			OP_BYTES: begin
				keep      = (byc != '0);
				cmd.bytes = (byc > 7'(MAX_BYTES)) ? 7'(MAX_BYTES) : byc;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = !cmd_valid_s1 || !q_full;
	assign in_acc   = s_tvalid && s_tready;
	assign q_push   = cmd_valid_s1 && !q_full;
	assign q_cmd    = cmd_s1;

	// one-entry holding stage in front of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else begin
			cmd_valid_s1 <= (in_acc && keep) || (cmd_valid_s1 && !q_push);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= cmd;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lcg48_cmd_fifo.sv =====
// Short command queue between the front end and the draw sequencer.
`default_nettype none
module lcg48_cmd_fifo #(
	parameter int unsigned DEPTH = lcg48_pkg::CMD_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lcg48_pkg::cmd_t wr_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 rd_valid,
	output lcg48_pkg::cmd_t      rd_cmd
);
	import lcg48_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lcg48_step.sv =====
// Generator state and its update, one 16-bit partial product per cycle.
`default_nettype none
module lcg48_step (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic                            seed_wr,
	input  wire logic [lcg48_pkg::STATE_W-1:0]   seed,
	output lcg48_pkg::lcg_rsp_t                  rsp,
	output logic [lcg48_pkg::STATE_W-1:0]        state
);
	import lcg48_pkg::*;

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] acc_q;
	logic [1:0]         chunk_q;
	logic               busy_q;
	logic [15:0]        chunk;
	logic [50:0]        prod;
	logic [STATE_W-1:0] addend;
	logic [STATE_W-1:0] acc_nxt;
	logic               last_chunk;

	// pick the state chunk and align its product
	always_comb begin
		case (chunk_q)
			2'd0:    chunk = state_q[15:0];
			2'd1:    chunk = state_q[31:16];
			default: chunk = state_q[47:32];
		endcase
		prod = chunk * LCG_MULT;
		case (chunk_q)
			2'd0:    addend = prod[47:0];
			2'd1:    addend = {prod[31:0], 16'b0};
			default: addend = {prod[15:0], 32'b0};
		endcase
		acc_nxt = acc_q + addend;
	end

	assign last_chunk = busy_q && (chunk_q == 2'd2);
	assign rsp.busy   = busy_q;
	assign rsp.done   = last_chunk;
	assign state      = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_W'(LCG_MULT);
			busy_q  <= 1'b0;
			chunk_q <= '0;
		end else if (seed_wr) begin
			state_q <= seed ^ STATE_W'(LCG_MULT);
			busy_q  <= 1'b0;
		end else if (start && !busy_q) begin
			busy_q  <= 1'b1;
			chunk_q <= '0;
		end else if (busy_q) begin
			chunk_q <= chunk_q + 1'b1;
			if (last_chunk) begin
				state_q <= acc_nxt;
				busy_q  <= 1'b0;
			end
		end
	end

	// accumulator starts at the increment
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= LCG_INC;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lcg48_div.sv =====
// Restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module lcg48_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lcg48_pkg::div_req_t req,
	output lcg48_pkg::div_rsp_t      rsp
);
	import lcg48_pkg::*;

	localparam int unsigned SW = $clog2(DIV_STEPS);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] dsr_q;
	logic [SW-1:0]    step_q;
	logic             busy_q;
	logic [DIV_W:0]   trial;
	logic             fits;
	logic             last_step;

	assign trial     = {rem_q, dvd_q[DIV_W-1]};
	assign fits      = (trial >= {1'b0, dsr_q});
	assign last_step = busy_q && (step_q == SW'(DIV_STEPS - 1));

	assign rsp.busy = busy_q;
	assign rsp.done = last_step;
	assign rsp.rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start && !busy_q) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift in one dividend bit, subtract when the divisor fits
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(trial - {1'b0, dsr_q}) : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lcg48_back.sv =====
// Back end: sequences draws per command and holds the result register.
`default_nettype none
module lcg48_back #(
	parameter int unsigned MAX_BYTES = lcg48_pkg::MAX_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_valid,
	input  wire lcg48_pkg::cmd_t                q_cmd,
	output logic                                q_pop,
	output logic                                lcg_start,
	input  wire lcg48_pkg::lcg_rsp_t            lcg_rsp,
	input  wire logic [lcg48_pkg::STATE_W-1:0]  lcg_state,
	output lcg48_pkg::div_req_t                 div_req,
	input  wire lcg48_pkg::div_rsp_t            div_rsp,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic signed [63:0]                  m_tdata,
	output logic                                m_tlast
);
	import lcg48_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_STEP  = 3'd1;
	localparam logic [2:0] S_USE   = 3'd2;
	localparam logic [2:0] S_PMUL  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_CHECK = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0]       st_q;
	cmd_t             cmd_q;
	logic             phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      hold_q;
	logic [30:0]      b_q;
	logic [61:0]      prod_q;
	logic [63:0]      res_q;
	logic             res_last_q;
	logic             out_valid_q;
	logic [63:0]      out_data_q;
	logic             out_last_q;

	logic [31:0]      top32;
	logic [30:0]      top31;
	logic [5:0]       shamt;
	logic [31:0]      topk;
	logic [63:0]      bits_val;
	logic [31:0]      rej_sum;
	logic             reject;
	logic             out_free;
	logic             more_bytes;

	assign top32 = lcg_state[47:16];
	assign top31 = lcg_state[47:17];

	// top k bits, sign-extended when all 32 are taken
	always_comb begin
		shamt = 6'd32 - cmd_q.bits;
		topk  = top32 >> shamt;
		if (cmd_q.bits == 6'd0) begin
			bits_val = '0;
		end else if (cmd_q.bits == 6'd32) begin
			bits_val = {{32{top32[31]}}, top32};
		end else begin
			bits_val = {32'b0, topk};
		end
	end

	// redraw when the draw falls in the incomplete last interval
	assign rej_sum = {1'b0, b_q} - {1'b0, div_rsp.rem} + {1'b0, cmd_q.bound} - 32'd1;
	assign reject  = rej_sum[31];

	assign out_free   = !out_valid_q || m_tready;
	assign more_bytes = (cmd_q.op == OP_BYTES) && (cnt_q != CNT_W'(1));

	always_comb begin
		q_pop            = (st_q == S_IDLE) && q_valid;
		lcg_start        = q_pop;
		div_req.start    = 1'b0;
		div_req.dividend = top31;
		div_req.divisor  = cmd_q.bound;
		case (st_q)
			S_USE: begin
				if ((cmd_q.op == OP_LONG || cmd_q.op == OP_DOUBLE) && !phase_q) begin
					lcg_start = 1'b1;
				end
				if (cmd_q.op == OP_BOUND && !cmd_q.pow2) begin
					div_req.start = 1'b1;
				end
			end
			S_CHECK: begin
				lcg_start = reject;
			end
			S_EMIT: begin
				lcg_start = out_free && more_bytes;
			end
			default: begin
				lcg_start = q_pop;
			end
		endcase
	end

	// draw sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						st_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (lcg_rsp.done) begin
						st_q <= S_USE;
					end
				end
				S_USE: begin
					case (cmd_q.op)
						OP_BITS, OP_BYTES: st_q <= S_EMIT;
						OP_LONG, OP_DOUBLE: st_q <= phase_q ? S_EMIT : S_STEP;
						OP_BOUND: st_q <= cmd_q.pow2 ? S_PMUL : S_DIV;
						default: st_q <= S_IDLE;
					endcase
				end
				S_PMUL: begin
					st_q <= S_EMIT;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						st_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					st_q <= reject ? S_STEP : S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						st_q <= more_bytes ? S_STEP : S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers of the current command
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					cmd_q   <= q_cmd;
					phase_q <= 1'b0;
					cnt_q   <= q_cmd.bytes[CNT_W-1:0];
				end
			end
			S_USE: begin
				res_last_q <= 1'b1;
				case (cmd_q.op)
					OP_BITS: begin
						res_q <= bits_val;
					end
					OP_LONG: begin
						hold_q  <= top32;
						phase_q <= 1'b1;
						res_q   <= {hold_q, 32'b0} + {{32{top32[31]}}, top32};
					end
					OP_DOUBLE: begin
						hold_q  <= {6'b0, lcg_state[47:22]};
						phase_q <= 1'b1;
						res_q   <= {11'b0, hold_q[25:0], lcg_state[47:21]};
					end
					OP_BOUND: begin
						prod_q <= top31 * cmd_q.bound;
						b_q    <= top31;
					end
					OP_BYTES: begin
						res_q      <= {56'b0, lcg_state[47:40]};
						res_last_q <= (cnt_q == CNT_W'(1));
					end
					default: begin
						res_q <= '0;
					end
				endcase
			end
			S_PMUL: begin
				res_q <= {33'b0, prod_q[61:31]};
			end
			S_CHECK: begin
				res_q <= {33'b0, div_rsp.rem};
			end
			S_EMIT: begin
				if (out_free && more_bytes) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// output register, freed by the downstream transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_EMIT && out_free) begin
			out_data_q <= res_q;
			out_last_q <= res_last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== test/lcg48_draw_checker.sv =====
// Checker for the LCG48 draw engine: follows the seed, request and result channels and predicts results.
`default_nettype none
module lcg48_draw_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [lcg48_pkg::STATE_W-1:0] cfg_data,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [47:0]                   s_tdata,  // bit_count[5:0], bound[36:6], byte_count[43:37]
	input  wire logic [2:0]                    s_tuser,  // op[2:0]
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [63:0]                   m_tdata,  // value[63:0]
	input  wire logic                          m_tlast,
	output int                                 fault_count,
	output int                                 results_owed
);
	import lcg48_pkg::*;

	typedef struct packed {
		logic [63:0] value;
		logic        last;
	} draw_t;

	localparam logic [STATE_W-1:0] MULT_48 = {13'd0, LCG_MULT};

	draw_t              draws_due[$];
	draw_t              head;
	logic [STATE_W-1:0] lcg_now = MULT_48;
	int                 fails = 0;

	// advance the generator one step and return its top k bits
	function automatic logic [63:0] step_top(input int unsigned k);
		lcg_now = lcg_now * MULT_48 + LCG_INC;
		if (k == 0)
			return 64'd0;
		if (k > 32)
			k = 32;
		return 64'(lcg_now >> (STATE_W - k));
	endfunction

	function automatic logic [63:0] widen32(input logic [63:0] x);
		return {{32{x[31]}}, x[31:0]};
	endfunction

	// work out every result one request causes, in order
	task automatic predict_draw(input logic [2:0] op, input logic [5:0] bc,
			input logic [30:0] lim, input logic [6:0] cnt);
		logic [63:0] v;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] b;
		logic [63:0] n;
		int unsigned k;
		n = {33'd0, lim};
		case (op)
			OP_BITS: begin
				k = (bc > 32) ? 32 : bc;
				v = step_top(k);
				if (k == 32)
					v = widen32(v);
				draws_due.push_back('{value: v, last: 1'b1});
			end
			OP_BOUND: begin
				// zero counts as a power of two here
				if ((lim & (~lim + 31'd1)) == lim) begin
					v = (step_top(31) * n) >> 31;
				end else begin
					// redraw while the attempt falls in the biased tail
					do begin
						b = step_top(31);
						v = b % n;
					end while (((b - v + n - 64'd1) & 64'hFFFF_FFFF) >= 64'h8000_0000);
				end
				draws_due.push_back('{value: v, last: 1'b1});
			end
			OP_LONG: begin
				hi = widen32(step_top(32));
				lo = widen32(step_top(32));
				draws_due.push_back('{value: (hi << 32) + lo, last: 1'b1});
			end
			OP_BOOL: begin
				draws_due.push_back('{value: step_top(1), last: 1'b1});
			end
			OP_FLOAT: begin
				draws_due.push_back('{value: step_top(24), last: 1'b1});
			end
			OP_DOUBLE: begin
				hi = step_top(26);
				lo = step_top(27);
				draws_due.push_back('{value: (hi << 27) + lo, last: 1'b1});
			end
			OP_BYTES: begin
				// saturate to the run limit; an empty run leaves the state alone
				k = (cnt > MAX_BYTES_DEF) ? MAX_BYTES_DEF : cnt;
				for (int unsigned i = 0; i < k; i++)
					draws_due.push_back('{value: step_top(8), last: (i + 1 == k)});
			end
			default: begin
			end
		endcase
	endtask

	// follow each transaction on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_now = MULT_48;
			draws_due.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				lcg_now = cfg_data ^ MULT_48;
			if (s_tvalid && s_tready)
				predict_draw(s_tuser, s_tdata[5:0], s_tdata[36:6], s_tdata[43:37]);
			if (m_tvalid && m_tready) begin
				if (draws_due.size() == 0) begin
					$error("result with none due: value %h last %b", m_tdata, m_tlast);
					fails++;
				end else begin
					head = draws_due.pop_front();
					if (m_tdata !== head.value) begin
						$error("value mismatch: expected %h, got %h", head.value, m_tdata);
						fails++;
					end
					if (m_tlast !== head.last) begin
						$error("last mismatch: expected %b, got %b", head.last, m_tlast);
						fails++;
					end
				end
			end
		end
		fault_count  <= fails;
		results_owed <= draws_due.size();
	end

endmodule
`default_nettype wire

// ===== test/tb_lcg48_random_draw_engine.sv =====
// Testbench top for the LCG48 draw engine: clock, reset, seed writes, requests and verdict.
`default_nettype none
module tb_lcg48_random_draw_engine;
	import lcg48_pkg::*;

	localparam logic [2:0] OP_SPARE    = 3'd7;
	localparam int SETTLE_CYCLES       = 100;
	localparam int LONG_HOLD_CYCLES    = 300;
	localparam int CYCLE_LIMIT         = 2_000_000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [STATE_W-1:0] cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [47:0]        s_tdata;  // bit_count[5:0], bound[36:6], byte_count[43:37]
	logic [2:0]         s_tuser;  // op[2:0]
	logic               m_tvalid;
	logic               m_tready;
	logic signed [63:0] m_tdata;  // value[63:0]
	logic               m_tlast;
	int                 fault_count;
	int                 results_owed;
	int                 cycle_count = 0;

	// idling controls shared with the result sink
	bit src_gaps    = 1'b0;
	bit sink_stalls = 1'b0;
	bit long_hold   = 1'b0;
	int stall_odds  = 8;

	lcg48_random_draw_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	lcg48_draw_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fault_count (fault_count),
		.results_owed(results_owed)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// result sink: random stall bursts, plus one long hold on request
	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (sink_stalls && $urandom_range(1, stall_odds) == 1) begin
				m_tready <= 1'b0;
				gap = $urandom_range(1, 19);
				repeat (gap) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// offer one request and hold it until the transaction completes
	task automatic send_request(input logic [2:0] op, input logic [5:0] bc,
			input logic [30:0] lim, input logic [6:0] cnt);
		int gap;
		@(negedge clk);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'd0, cnt, lim, bc};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and let every due result come out
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [STATE_W-1:0] seed);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random requests until the given number of result-bearing ones went in
	task automatic random_phase(input int items, input int drain_at);
		int         sent;
		int         pick;
		logic [2:0] op;
		logic [5:0] bc;
		logic [30:0] lim;
		logic [6:0] cnt;
		sent = 0;
		while (sent < items) begin
			op = ($urandom_range(0, 24) == 0) ? OP_SPARE : 3'($urandom_range(0, 6));
			bc = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) :
				6'($urandom_range(1, 32));
			case ($urandom_range(0, 9))
				0: lim = 31'd1 << $urandom_range(0, 30);
				1, 2: lim = 31'($urandom_range(1, 100));
				// just above half range: frequent redraws
				3: lim = 31'h4000_0000 + 31'($urandom_range(1, 4096));
				4: lim = ($urandom_range(0, 3) == 0) ? 31'd0 :
					31'h7FFF_FFFF - 31'($urandom_range(0, 15));
				default: lim = 31'($urandom());
			endcase
			pick = $urandom_range(0, 19);
			if (pick < 17)
				cnt = 7'($urandom_range(1, 8));
			else if (pick < 19)
				cnt = 7'($urandom_range(9, 64));
			else
				cnt = 7'($urandom_range(0, 127));
			send_request(op, bc, lim, cnt);
			if (op != OP_SPARE && !(op == OP_BYTES && cnt == 0))
				sent++;
			if (sent == drain_at)
				wait_drained();
		end
	endtask

	initial begin : stimulus
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_BITS;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and corner cases, from the reset seed
		send_request(OP_BITS, 6'd0, 31'($urandom()), 7'($urandom()));
		send_request(OP_BITS, 6'd1, 31'($urandom()), 7'($urandom()));
		send_request(OP_BITS, 6'd31, 31'($urandom()), 7'($urandom()));
		send_request(OP_BITS, 6'd32, 31'($urandom()), 7'($urandom()));
		send_request(OP_BITS, 6'd33, 31'($urandom()), 7'($urandom()));
		send_request(OP_BITS, 6'd63, 31'h7FFF_FFFF, 7'h7F);
		send_request(OP_BOUND, 6'($urandom()), 31'd0, 7'($urandom()));
		send_request(OP_BOUND, 6'($urandom()), 31'd1, 7'($urandom()));
		send_request(OP_BOUND, 6'($urandom()), 31'h4000_0000, 7'($urandom()));
		send_request(OP_BOUND, 6'($urandom()), 31'h7FFF_FFFF, 7'($urandom()));
		send_request(OP_BOUND, 6'($urandom()), 31'd3, 7'($urandom()));
		send_request(OP_BOUND, 6'($urandom()), 31'h4000_0001, 7'($urandom()));
		wait_drained();
		write_seed('1);
		send_request(OP_LONG, 6'($urandom()), 31'($urandom()), 7'($urandom()));
		send_request(OP_BOOL, 6'($urandom()), 31'($urandom()), 7'($urandom()));
		send_request(OP_FLOAT, 6'($urandom()), 31'($urandom()), 7'($urandom()));
		send_request(OP_DOUBLE, 6'($urandom()), 31'($urandom()), 7'($urandom()));
		send_request(OP_BYTES, 6'($urandom()), 31'($urandom()), 7'd0);
		send_request(OP_BYTES, 6'($urandom()), 31'($urandom()), 7'd1);
		send_request(OP_BYTES, 6'($urandom()), 31'($urandom()), 7'd64);
		send_request(OP_BYTES, 6'($urandom()), 31'($urandom()), 7'd65);
		send_request(OP_BYTES, 6'd0, 31'd0, 7'h7F);
		send_request(OP_SPARE, 6'($urandom()), 31'($urandom()), 7'($urandom()));
		wait_drained();

		// seed giving an all-zero state, idling on both sides
		write_seed(STATE_W'({13'd0, LCG_MULT}));
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		stall_odds  = 8;
		random_phase(40, -1);
		wait_drained();

		// random seed, long sink hold at the start and a full drain midway
		write_seed(STATE_W'({$urandom(), $urandom()}));
		@(posedge clk);
		long_hold = 1'b1;
		random_phase(40, 20);
		wait_drained();

		// seed one, sparse stalls
		write_seed(STATE_W'(1));
		stall_odds = 30;
		random_phase(40, -1);
		wait_drained();

		// random seed, sender gaps only
		write_seed(STATE_W'({$urandom(), $urandom()}));
		sink_stalls = 1'b0;
		random_phase(40, -1);
		wait_drained();

		// seed zero, no idling at all
		write_seed('0);
		src_gaps = 1'b0;
		random_phase(40, -1);
		wait_drained();

		if (fault_count == 0 && results_owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
